// ===== rtl/bfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// bfrs_pkg
// shared request codes and field widths for the byte frequency rank sorter
// ----------------------------------------------------------------------------
package bfrs_pkg;
  localparam int SYM_W = 8;
  localparam int SYMS  = 256;
  localparam int DIST_W = 9;
  localparam int OUT_CNT_W = 32;

  typedef logic [1:0] req_t;
  localparam req_t REQ_ADD   = 2'd0;
  localparam req_t REQ_READ  = 2'd1;
  localparam req_t REQ_CLEAR = 2'd2;
  localparam req_t REQ_NONE  = 2'd3;
endpackage

// ===== rtl/byte_frequency_rank_sorter_core.sv =====
// ----------------------------------------------------------------------------
// byte_frequency_rank_sorter_core
// byte histogram with rank sort by ascending count, then ascending symbol
// ----------------------------------------------------------------------------
// channel  | handshake          | fields
// input    | start / busy       | in_req_type in_byte_value in_is_last in_rank
// result   | out_valid (strobe) | out_symbol out_count out_distinct_total
//          |                    | out_entry_valid
//
// add: busy through count read, increment and write, and strobe set up; the
// result strobes in the cycle after, so a new item is taken only once the last
// one is through
// read: busy through rank read, count read and range check
// add with last: plus 256 rank steps (count fetch, wait, compare sweep over all
// symbols on one shared comparator, slot write)
// clear: busy sweep over all count words, one count word a cycle, result strobed
// in its first cycle; after reset the same clearing pass runs with busy high
// the receiver cannot stall: each result shows for one cycle.
// ----------------------------------------------------------------------------
module byte_frequency_rank_sorter_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  bfrs_pkg::req_t             in_req_type,
  input  logic [7:0]                 in_byte_value,
  input  logic                       in_is_last,
  input  logic [7:0]                 in_rank,
  output logic                       out_valid,
  output logic [7:0]                 out_symbol,
  output logic [31:0]                out_count,
  output logic [8:0]                 out_distinct_total,
  output logic                       out_entry_valid
);
  import bfrs_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  // state codes
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ARD   = 4'd2;  // count word being read
  localparam logic [3:0] S_AWR   = 4'd3;  // increment and write back
  localparam logic [3:0] S_OUT   = 4'd4;  // strobe result
  localparam logic [3:0] S_RRD   = 4'd5;  // sorted entry being read
  localparam logic [3:0] S_RCNT  = 4'd6;  // count of that symbol being read
  localparam logic [3:0] S_RCAP  = 4'd7;
  localparam logic [3:0] S_SA    = 4'd8;  // fetch count of outer symbol
  localparam logic [3:0] S_SAW   = 4'd9;
  localparam logic [3:0] S_SB    = 4'd10; // compare with inner symbol
  localparam logic [3:0] S_SWR   = 4'd11; // write rank slot

  logic [3:0]             st_r, st_nxt;
  logic [COUNT_WIDTH-1:0] cmem [SYMS];
  logic [SYM_W-1:0]       smem [SYMS];

  logic [SYM_W-1:0]       a_r;          // outer symbol / address
  logic [8:0]             b_r;          // inner sweep counter
  logic [8:0]             pos_r;
  logic [COUNT_WIDTH-1:0] ca_r;         // outer count
  logic [COUNT_WIDTH-1:0] rd_r;         // registered count read
  logic [SYM_W-1:0]       srd_r;        // registered sorted read
  logic [SYM_W-1:0]       rd_addr;
  logic                   last_r;
  logic [8:0]             dist_r;
  logic [7:0]             o_sym_r;
  logic [COUNT_WIDTH-1:0] o_cnt_r;
  logic                   o_ev_r;
  logic                   o_v_r;

  // count memory port
  logic                   cwe;
  logic [SYM_W-1:0]       cwa;
  logic [COUNT_WIDTH-1:0] cwd;

  always_comb begin
    rd_addr = a_r;
    if (st_r == S_RCNT) rd_addr = srd_r;
    else if (st_r == S_SB) rd_addr = b_r[7:0];
  end

  always_ff @(posedge clk) begin
    if (cwe) cmem[cwa] <= cwd;
    rd_r <= cmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_SWR && ca_r != '0) smem[pos_r[7:0]] <= a_r;
    srd_r <= smem[a_r];
  end

  // shared comparator: does inner symbol rank before outer one
  logic inner_first;
  logic [8:0] b_prev;
  assign b_prev = b_r - 9'd1;
  assign inner_first = (rd_r != '0) && (b_prev[7:0] != a_r) &&
                       ((rd_r < ca_r) || (rd_r == ca_r && b_prev[7:0] < a_r));

  assign cwe = (st_r == S_CLR) || (st_r == S_AWR);
  assign cwa = a_r;
  assign cwd = (st_r == S_CLR) ? '0 : ((rd_r == CMAX) ? rd_r : rd_r + 1'b1);

  function automatic logic [31:0] cap(input logic [COUNT_WIDTH-1:0] c);
    logic [31:0] r;
    if (COUNT_WIDTH > 32) r = (c > COUNT_WIDTH'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(c);
    else r = 32'(c);
    return r;
  endfunction

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLR:  if (a_r == 8'hFF) st_nxt = S_IDLE;
      S_IDLE: if (start) begin
        unique case (in_req_type)
          REQ_ADD:   st_nxt = S_ARD;
          REQ_READ:  st_nxt = S_RRD;
          REQ_CLEAR: st_nxt = S_CLR;
          default:   st_nxt = S_OUT;
        endcase
      end
      S_ARD:  st_nxt = S_AWR;
      S_AWR:  st_nxt = last_r ? S_SA : S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      S_RRD:  st_nxt = S_RCNT;
      S_RCNT: st_nxt = S_RCAP;
      S_RCAP: st_nxt = S_IDLE;
      S_SA:   st_nxt = S_SAW;
      S_SAW:  st_nxt = S_SB;
      S_SB:   if (b_r == 9'd256) st_nxt = S_SWR;
      S_SWR:  st_nxt = (a_r == 8'hFF) ? S_OUT : S_SA;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      a_r <= '0;
      dist_r <= '0;
      o_v_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      // strobe after an add, read or no-op ends, and right after a clear is taken
      o_v_r <= (st_r == S_OUT) || (st_r == S_RCAP) ||
               (st_r == S_IDLE && start && in_req_type == REQ_CLEAR);
      unique case (st_r)
        S_CLR: a_r <= a_r + 8'd1;
        S_IDLE: if (start) begin
          // last only matters on an add
          last_r <= in_is_last && (in_req_type == REQ_ADD);
          a_r <= (in_req_type == REQ_READ) ? in_rank :
                 ((in_req_type == REQ_CLEAR) ? 8'd0 : in_byte_value);
          o_sym_r <= (in_req_type == REQ_ADD) ? in_byte_value : 8'd0;
          o_cnt_r <= '0; o_ev_r <= 1'b0;
          if (in_req_type == REQ_CLEAR) dist_r <= '0;
        end
        S_ARD: ;
        S_AWR: begin
          if (rd_r == '0) dist_r <= dist_r + 9'd1;
          o_cnt_r <= cwd;
          o_sym_r <= a_r;
          if (last_r) a_r <= '0;
        end
        S_OUT: ;
        S_RRD: ;
        S_RCNT: o_sym_r <= srd_r;
        S_RCAP: begin
          if ({1'b0, a_r} < dist_r) begin
            o_cnt_r <= rd_r; o_ev_r <= 1'b1;
          end else begin
            o_sym_r <= '0; o_cnt_r <= '0;
          end
        end
        S_SA: begin b_r <= '0; pos_r <= '0; end
        S_SAW: begin ca_r <= rd_r; b_r <= 9'd0; end
        S_SB: begin
          b_r <= b_r + 9'd1;
          if (b_r != 9'd0 && inner_first) pos_r <= pos_r + 9'd1;
        end
        S_SWR: a_r <= a_r + 8'd1;
        default: ;
      endcase
    end
  end

  // result of the add is latched before the sort; restore symbol at end
  logic [7:0] add_sym_r;
  logic [COUNT_WIDTH-1:0] add_cnt_r;
  always_ff @(posedge clk) begin
    if (st_r == S_AWR) begin
      add_sym_r <= a_r;
      add_cnt_r <= cwd;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = o_v_r;
  assign out_symbol = last_r ? add_sym_r : o_sym_r;
  assign out_count = last_r ? cap(add_cnt_r) : cap(o_cnt_r);
  assign out_distinct_total = dist_r;
  assign out_entry_valid = o_ev_r;
endmodule

// ===== rtl/bfrs_checker.sv =====
// ----------------------------------------------------------------------------
// bfrs_checker
// port-level checks for the rank sorter
// ----------------------------------------------------------------------------
module bfrs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [8:0] out_distinct_total,
  input logic       out_entry_valid
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after accept");
  a_no_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start)) else $error("strobe without item");
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!start && !busy) |=> !busy) else $error("busy without an item");
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_distinct_total <= 9'd256) else $error("distinct total out of range");
  a_entry_needs_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_valid) |-> (out_distinct_total != 9'd0))
    else $error("valid entry with no distinct symbols");
endmodule

bind byte_frequency_rank_sorter_core bfrs_checker u_bfrs_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_distinct_total(out_distinct_total), .out_entry_valid(out_entry_valid)
);
